// ===== sv/mct_pkg.sv =====
// Shared types, codes and defaults for the multiset counter table.
`default_nettype none

package mct_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_KEY_WIDTH   = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    // Operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_COUNT   = 2'd1;
    localparam logic [1:0] OP_POPULAR = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;   // latch the beat, reset the scan
        logic scan;    // walk the stored entries
        logic commit;  // update the table, load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;  // search finished or key found
        logic out_free;   // result register can take a new beat
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/mct_ctrl.sv =====
// Controller state machine for the multiset counter table.
`default_nettype none

module mct_ctrl
    import mct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire dp_status_t dp_status,
    output ctrl_cmd_t       ctrl_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    ctrl_cmd.start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl_cmd.scan = 1'b1;
                if (dp_status.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // hold until the result register has room
                if (dp_status.out_free)
                begin
                    ctrl_cmd.commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mct_datapath.sv =====
// Entry memory, scan logic, fill count and result register of the counter table.
`default_nettype none

module mct_datapath
    import mct_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int FILL_W      = $clog2(CAPACITY + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctrl_cmd_t              ctrl_cmd,
    output dp_status_t                  dp_status,
    input  wire logic [1:0]             operation,
    input  wire logic [KEY_WIDTH-1:0]   key,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [COUNT_WIDTH-1:0]      count_out,
    output logic [KEY_WIDTH-1:0]        popular_key,
    output logic [FILL_W-1:0]           distinct_total,
    output logic [1:0]                  status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int WW = KEY_WIDTH + COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [FILL_W-1:0]      FILL_MAX  = FILL_W'(CAPACITY);

    // Entries below fill_reg are the valid ones: keys are never removed
    logic [WW-1:0] mem [CAPACITY];

    logic [FILL_W-1:0]      fill_reg;
    logic [1:0]             op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [FILL_W-1:0]      scan_cnt_reg;
    logic                   rd_valid_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic [WW-1:0]          rd_data_reg;
    logic                   hit_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg;
    logic                   best_found_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [KEY_WIDTH-1:0]   best_key_reg;
    logic                   out_valid_reg;

    logic [FILL_W-1:0]      scan_limit;
    logic                   issue;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                   key_match;
    logic                   best_take;

    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [WW-1:0]          mem_wdata;
    logic [FILL_W-1:0]      fill_next;
    logic [COUNT_WIDTH-1:0] res_count;
    logic [KEY_WIDTH-1:0]   res_key;
    logic [1:0]             res_status;
    logic [COUNT_WIDTH-1:0] inc_cnt;

    assign rd_key = rd_data_reg[WW-1:COUNT_WIDTH];
    assign rd_cnt = rd_data_reg[COUNT_WIDTH-1:0];

    always_comb
    begin
        if (op_reg inside {OP_ADD, OP_COUNT, OP_POPULAR})
        begin
            scan_limit = fill_reg;
        end
        else
        begin
            scan_limit = '0;
        end
    end

    assign issue     = ctrl_cmd.scan && !hit_reg && (scan_cnt_reg < scan_limit);
    assign key_match = rd_valid_reg && (rd_key == key_reg)
                       && ((op_reg == OP_ADD) || (op_reg == OP_COUNT));
    assign best_take = rd_valid_reg && (op_reg == OP_POPULAR)
                       && (!best_found_reg || (rd_cnt > best_cnt_reg)
                           || ((rd_cnt == best_cnt_reg) && (rd_key < best_key_reg)));

    assign dp_status.scan_done = hit_reg || ((scan_cnt_reg >= scan_limit) && !rd_valid_reg);
    assign dp_status.out_free  = !out_valid_reg || !result_stall;

    assign inc_cnt = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + 1'b1;

    // Table update and result for the finished search
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = hit_idx_reg;
        mem_wdata  = {key_reg, inc_cnt};
        fill_next  = fill_reg;
        res_count  = '0;
        res_key    = '0;
        res_status = STAT_OK;
        case (op_reg)
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    mem_we    = ctrl_cmd.commit;
                    res_count = inc_cnt;
                end
                else if (fill_reg != FILL_MAX)
                begin
                    mem_we    = ctrl_cmd.commit;
                    mem_waddr = fill_reg[IW-1:0];
                    mem_wdata = {key_reg, COUNT_WIDTH'(1)};
                    fill_next = fill_reg + 1'b1;
                    res_count = COUNT_WIDTH'(1);
                end
                else
                begin
                    res_status = STAT_FULL;
                end
            end
            OP_COUNT:
            begin
                if (hit_reg)
                begin
                    res_count = hit_cnt_reg;
                end
            end
            OP_POPULAR:
            begin
                if (best_found_reg)
                begin
                    res_count = best_cnt_reg;
                    res_key   = best_key_reg;
                end
                else
                begin
                    res_status = STAT_EMPTY;
                end
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_cnt_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (ctrl_cmd.start)
            begin
                scan_cnt_reg   <= '0;
                hit_reg        <= 1'b0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (key_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (best_take)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (ctrl_cmd.commit)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.start)
        begin
            op_reg  <= operation;
            key_reg <= key;
        end
        rd_idx_reg <= scan_cnt_reg[IW-1:0];
        if (key_match && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_cnt_reg <= rd_cnt;
        end
        if (best_take)
        begin
            best_cnt_reg <= rd_cnt;
            best_key_reg <= rd_key;
        end
        if (ctrl_cmd.commit)
        begin
            count_out      <= res_count;
            popular_key    <= res_key;
            distinct_total <= fill_next;
            status         <= res_status;
        end
    end

    assign result_valid = out_valid_reg;

    // A returned read always comes from an entry that has been written
    a_read_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (FILL_W'(rd_idx_reg) < fill_reg))
        else $error("scan read beyond filled entries");

    // The fill count only ever grows by one, and only on a commit
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            ((fill_reg == $past(fill_reg) + 1'b1) && $past(ctrl_cmd.commit)))
        else $error("fill count moved unexpectedly");

    // A hit is only recorded for lookups, never for the popular query
    a_hit_op: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> ((op_reg == OP_ADD) || (op_reg == OP_COUNT)))
        else $error("hit recorded for a non-lookup operation");

    // A commit never overwrites a result beat still waiting downstream
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.commit && out_valid_reg) |-> !result_stall)
        else $error("result beat overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/multiset_counter_table_unit.sv =====
// Top level of the multiset counter table: controller plus datapath.
// The unit keeps a bag of up to CAPACITY distinct keys, each with a saturating
// occurrence count. Operation 0 adds a key (a new key takes the next free entry
// with count 1, a stored key has its count bumped and held at its maximum),
// operation 1 returns a key's count or 0 when absent, operation 2 returns the
// key with the highest count, the smaller key winning a tie. Every result beat
// also carries the number of distinct keys stored. Adding a new key to a full
// table drops it and reports status 1; asking for the most popular key of an
// empty bag reports status 2. Operation 3 changes nothing and returns zeros.
// Throughput: the unit handles one item at a time. Each item walks the filled
// entries through the single read port of the entry memory, one entry per
// cycle, visiting all stored keys for the popular query or a missing key,
// fewer when a lookup finds its key early, and at most CAPACITY entries. The
// result sits in an output register, so a stalled result beat does not stop
// the next item from being accepted and scanned; only its commit waits for the
// register to drain. Entries fill from the bottom and are never freed, so a
// fill count stands for the valid bits and no clearing pass is needed after
// reset.
`default_nettype none

module multiset_counter_table_unit
    import mct_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int FILL_W      = $clog2(CAPACITY + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // item channel
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic [1:0]             operation,
    input  wire logic [KEY_WIDTH-1:0]   key,
    // result channel
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [COUNT_WIDTH-1:0]      count_out,
    output logic [KEY_WIDTH-1:0]        popular_key,
    output logic [FILL_W-1:0]           distinct_total,
    output logic [1:0]                  status
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // Sequence each beat: accept, scan, commit
    mct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp_status  (dp_status),
        .ctrl_cmd   (ctrl_cmd)
    );

    // Hold the table, run the search, register the result beat
    mct_datapath #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .FILL_W      (FILL_W)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl_cmd       (ctrl_cmd),
        .dp_status      (dp_status),
        .operation      (operation),
        .key            (key),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .count_out      (count_out),
        .popular_key    (popular_key),
        .distinct_total (distinct_total),
        .status         (status)
    );

endmodule

`default_nettype wire

// ===== bench/bag_tracker_pkg.sv =====
// Scoreboard class for the multiset counter table: result prediction and beat checks.
package bag_tracker_pkg;

    import mct_pkg::*;

    localparam int KW = DEF_KEY_WIDTH;
    localparam int CW = DEF_COUNT_WIDTH;
    localparam int TW = $clog2(DEF_CAPACITY + 1);

    // The unused operation code has no name in the design package
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [CW-1:0] count;
        logic [KW-1:0] pop;
        logic [TW-1:0] total;
        logic [1:0]    status;
    } bag_result_t;

    class bag_tracker;

        logic [KW-1:0] stored_keys [DEF_CAPACITY];
        logic [CW-1:0] stored_counts [DEF_CAPACITY];
        int unsigned   fill;
        bag_result_t   expected_beats [$];
        int unsigned   mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        // Apply one accepted item to the tracked bag and queue its result.
        function void take_item(logic [1:0] op, logic [KW-1:0] k);
            bag_result_t r;
            int slot;
            int best;
            r = '0;
            slot = -1;
            best = 0;
            // Entries fill from the bottom and are never freed
            for (int j = 0; j < fill; j++)
            begin
                if (slot < 0 && stored_keys[j] == k)
                    slot = j;
            end
            case (op)
                OP_ADD:
                begin
                    if (slot >= 0)
                    begin
                        if (stored_counts[slot] != '1)
                            stored_counts[slot]++;
                        r.count = stored_counts[slot];
                    end
                    else if (fill < DEF_CAPACITY)
                    begin
                        stored_keys[fill] = k;
                        stored_counts[fill] = 1;
                        fill++;
                        r.count = 1;
                    end
                    else
                        r.status = STAT_FULL;
                end
                OP_COUNT:
                begin
                    if (slot >= 0)
                        r.count = stored_counts[slot];
                end
                OP_POPULAR:
                begin
                    if (fill == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        // Highest count wins, smaller key on a tie
                        for (int j = 1; j < fill; j++)
                        begin
                            if (stored_counts[j] > stored_counts[best] ||
                                (stored_counts[j] == stored_counts[best] &&
                                 stored_keys[j] < stored_keys[best]))
                                best = j;
                        end
                        r.count = stored_counts[best];
                        r.pop = stored_keys[best];
                    end
                end
                default:
                begin
                end
            endcase
            r.total = TW'(fill);
            expected_beats.push_back(r);
        endfunction

        // Compare one result beat against the oldest queued result.
        function void check_beat(logic [CW-1:0] count, logic [KW-1:0] pop,
                                 logic [TW-1:0] total, logic [1:0] status);
            bag_result_t e;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with no item outstanding");
                mismatches++;
                return;
            end
            e = expected_beats.pop_front();
            if (count !== e.count)
            begin
                if (mismatches < 100)
                    $error("count_out: expected %0d, got %0d", e.count, count);
                mismatches++;
            end
            if (pop !== e.pop)
            begin
                if (mismatches < 100)
                    $error("popular_key: expected %0d, got %0d", e.pop, pop);
                mismatches++;
            end
            if (total !== e.total)
            begin
                if (mismatches < 100)
                    $error("distinct_total: expected %0d, got %0d", e.total, total);
                mismatches++;
            end
            if (status !== e.status)
            begin
                if (mismatches < 100)
                    $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ===== bench/tb.sv =====
// Testbench top for the multiset counter table unit.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mct_pkg::*;
    import bag_tracker_pkg::*;

    // Random items after the directed opening
    localparam int RANDOM_ITEMS = 1830;
    // Keys drawn in the random part; more than the table holds so it overflows
    localparam int POOL_SIZE    = 96;
    // One item walks at most CAPACITY entries; the drain wait leaves room beyond that
    localparam int DRAIN_CYCLES = 2 * DEF_CAPACITY + 16;
    // Several times the run length with every scan and every stall at its longest
    localparam int CYCLE_LIMIT  = 2000000;
    // Long receiver hold-off that backs the unit up into its input
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT_BEAT = 300;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    logic [1:0]    operation;
    logic [KW-1:0] key;
    logic          result_valid;
    logic          result_stall;
    logic [CW-1:0] count_out;
    logic [KW-1:0] popular_key;
    logic [TW-1:0] distinct_total;
    logic [1:0]    status;

    bag_tracker    tracker = new();

    logic [KW-1:0] key_pool [POOL_SIZE];
    int unsigned   burst_left;
    bit            pacing_on;
    int unsigned   cycles;

    multiset_counter_table_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .key            (key),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .count_out      (count_out),
        .popular_key    (popular_key),
        .distinct_total (distinct_total),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run if the unit stops making progress.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // After a burst of beats, drop valid for a random gap. Most gaps are short;
    // some are long enough to land in any part of an entry scan.
    task automatic pace_sender();
        int unsigned gap;
        if (!pacing_on)
            return;
        if (burst_left != 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 30);
        if ($urandom_range(0, 3) == 0)
            gap = $urandom_range(10, 80);
        else
            gap = $urandom_range(1, 6);
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Offer one item beat, hold it until the unit takes it, then log it with
    // the tracker. Valid stays high into the next beat unless pacing drops it.
    task automatic send_item(input logic [1:0] op, input logic [KW-1:0] k);
        item_valid <= 1'b1;
        operation  <= op;
        key        <= k;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tracker.take_item(op, k);
        pace_sender();
    endtask

    // Result side: check every accepted beat and stall on one of four patterns
    // that the tick counter redraws at random. Once, after a few hundred beats,
    // hold the channel off for a long stretch so the output register and the
    // scan both fill and the unit has to stall its input.
    initial
    begin : result_sink
        int unsigned beats;
        int unsigned hold_left;
        int unsigned mode;
        int unsigned tick;
        bit          hold_done;
        beats = 0;
        hold_left = 0;
        mode = 0;
        tick = 0;
        hold_done = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                tracker.check_beat(count_out, popular_key, distinct_total, status);
                beats++;
            end
            if (tick % 256 == 0)
                mode = $urandom_range(0, 3);
            tick++;
            if (!hold_done && beats == HOLD_AT_BEAT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ((tick % 7) < 3);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned   span;
        int unsigned   pick;
        logic [1:0]    op;
        logic [KW-1:0] k;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        operation  <= OP_ADD;
        key        <= '0;
        burst_left = 0;
        pacing_on  = 1'b1;

        // Seed the key pool with the extremes and near-extremes, fill the rest
        for (int j = 0; j < POOL_SIZE; j++)
            key_pool[j] = KW'($urandom_range(0, 65535));
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 16'h0001;
        key_pool[3] = 16'hFFFE;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. Empty bag first: popular query reports empty,
        // count of an absent key is zero, the unused operation does nothing.
        send_item(OP_POPULAR, 16'h1234);
        send_item(OP_COUNT, 16'h0000);
        send_item(OP_NONE, 16'hFFFF);
        // All-ones key lands in entry 0
        send_item(OP_ADD, 16'hFFFF);
        send_item(OP_ADD, 16'hFFFF);
        send_item(OP_ADD, 16'h5555);
        send_item(OP_POPULAR, 16'h0000);
        // Tie at count 2: the smaller key wins though it sits in a later entry
        send_item(OP_ADD, 16'h5555);
        send_item(OP_POPULAR, 16'hFFFF);
        send_item(OP_ADD, 16'h0000);
        send_item(OP_ADD, 16'h0000);
        send_item(OP_POPULAR, 16'hAAAA);
        send_item(OP_COUNT, 16'hFFFF);
        send_item(OP_COUNT, 16'h5555);
        send_item(OP_COUNT, 16'h0000);
        send_item(OP_COUNT, 16'h1234);
        send_item(OP_NONE, 16'h0000);
        send_item(OP_ADD, 16'h0000);
        send_item(OP_POPULAR, 16'h5555);
        send_item(OP_ADD, 16'hAAAA);
        send_item(OP_COUNT, 16'hAAAA);

        // Random part. Widen the key pool slowly so the table spends a long
        // time partly filled before it overflows and new keys get dropped.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            span = (i / 10 + 8 < POOL_SIZE) ? i / 10 + 8 : POOL_SIZE;
            k = key_pool[$urandom_range(0, span - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 50)
                op = OP_ADD;
            else if (pick < 75)
            begin
                op = OP_COUNT;
                // Mostly stored keys; now and then a key that is likely absent
                if ($urandom_range(0, 4) == 0)
                    k = KW'($urandom);
            end
            else if (pick < 95)
            begin
                op = OP_POPULAR;
                k = KW'($urandom);
            end
            else
            begin
                op = OP_NONE;
                k = KW'($urandom);
            end
            send_item(op, k);
        end

        // Closing run back to back on the full table
        pacing_on = 1'b0;
        send_item(OP_ADD, 16'hFFFF);
        send_item(OP_POPULAR, 16'h0000);
        send_item(OP_COUNT, 16'hFFFF);
        send_item(OP_ADD, KW'($urandom));
        item_valid <= 1'b0;

        // Drain: wait for every queued result, then let the unit settle
        while (tracker.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.expected_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mct_pkg.sv
sv/mct_ctrl.sv
sv/mct_datapath.sv
sv/multiset_counter_table_unit.sv
bench/bag_tracker_pkg.sv
bench/tb.sv
